// ----- src/dq_pkg.sv -----
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types and constants for the double-ended queue unit.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int DEPTH   = 16;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int SUM_W   = CNT_W + 1;
  localparam int DATA_W  = 32;
  localparam int MODE_W  = 3;
  localparam int STAT_W  = 2;

  // result queue between the front end and the output stage
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_LIST       = 3'd4
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    FE_ACCEPT,
    FE_LIST
  } fe_state_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    status_t                  status;
    logic                     final_item;
  } res_t;

  typedef struct packed {
    logic valid;
    res_t res;
  } q_wr_t;

  // ring position of base + off, off below DEPTH
  function automatic idx_t ring_add(idx_t base, cnt_t off);
    logic [SUM_W-1:0] s;
    s = SUM_W'(base) + SUM_W'(off);
    if (s >= SUM_W'(DEPTH)) begin
      s = s - SUM_W'(DEPTH);
    end
    return IDX_W'(s);
  endfunction

endpackage

// ----- src/dq_if.sv -----
// ----------------------------------------------------------------------------
// dq_if
// Valid/ready channels for operation requests and results.
// ----------------------------------------------------------------------------
interface dq_in_if;
  logic                              valid;
  logic                              ready;
  logic [dq_pkg::MODE_W-1:0]         mode;
  logic signed [dq_pkg::DATA_W-1:0]  value_in;

  modport source(output valid, mode, value_in, input ready);
  modport sink(input valid, mode, value_in, output ready);
endinterface

interface dq_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [dq_pkg::DATA_W-1:0]  value_out;
  logic [dq_pkg::STAT_W-1:0]         status;
  logic                              final_item;

  modport source(output valid, value_out, status, final_item, input ready);
  modport sink(input valid, value_out, status, final_item, output ready);
endinterface

// ----- src/dq_ram.sv -----
// ----------------------------------------------------------------------------
// dq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- src/dq_queue.sv -----
// ----------------------------------------------------------------------------
// dq_queue
// Short result queue between the front end and the output stage.
// ----------------------------------------------------------------------------
module dq_queue (
  input  logic                        clk,
  input  logic                        rst_n,
  input  dq_pkg::q_wr_t               wr,
  input  logic                        rd_en,
  output dq_pkg::res_t                rd_data,
  output logic [dq_pkg::QCNT_W-1:0]   count
);

  dq_pkg::res_t                entry_r [dq_pkg::QDEPTH];
  logic [dq_pkg::QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [dq_pkg::QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [dq_pkg::QCNT_W-1:0]   count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr.valid) begin
      wr_ptr_nxt = wr_ptr_r + dq_pkg::QPTR_W'(1);
    end
    if (rd_en) begin
      rd_ptr_nxt = rd_ptr_r + dq_pkg::QPTR_W'(1);
    end
    if (wr.valid && !rd_en) begin
      count_nxt = count_r + dq_pkg::QCNT_W'(1);
    end else if (!wr.valid && rd_en) begin
      count_nxt = count_r - dq_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.valid) begin
      entry_r[wr_ptr_r] <= wr.res;
    end
  end

  assign rd_data = entry_r[rd_ptr_r];
  assign count   = count_r;

endmodule

// ----- src/dq_front.sv -----
// ----------------------------------------------------------------------------
// dq_front
// Accept and classify operations, keep ring bookkeeping, access the store.
// ----------------------------------------------------------------------------
module dq_front (
  input  logic                       clk,
  input  logic                       rst_n,
  dq_in_if.sink                      in_ch,
  input  logic [dq_pkg::QCNT_W-1:0]  q_count,
  output dq_pkg::q_wr_t              q_wr
);

  dq_pkg::fe_state_t state_r, state_nxt;
  dq_pkg::idx_t      front_r, front_nxt;
  dq_pkg::cnt_t      count_r, count_nxt;
  dq_pkg::cnt_t      lidx_r, lidx_nxt;

  logic              s1_valid_r, s1_valid_nxt;
  logic              s1_ram_r, s1_ram_nxt;
  dq_pkg::status_t   s1_status_r, s1_status_nxt;
  logic              s1_final_r, s1_final_nxt;

  logic                      accept;
  logic                      credit_ok;
  logic                      list_last;
  logic                      wr_en, rd_en;
  dq_pkg::idx_t              wr_addr, rd_addr;
  logic [dq_pkg::DATA_W-1:0] rd_data;
  dq_pkg::idx_t              front_dec;

  // room for one more result, counting the one in the read stage
  assign credit_ok = ((dq_pkg::QCNT_W + 1)'(q_count) + (dq_pkg::QCNT_W + 1)'(s1_valid_r))
                     < (dq_pkg::QCNT_W + 1)'(dq_pkg::QDEPTH);
  assign accept    = in_ch.valid && in_ch.ready;
  assign list_last = (lidx_r == count_r - dq_pkg::CNT_W'(1));
  assign front_dec = (front_r == '0) ? dq_pkg::IDX_W'(dq_pkg::DEPTH - 1)
                                     : front_r - dq_pkg::IDX_W'(1);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dq_pkg::FE_ACCEPT: begin
        if (accept && in_ch.mode == dq_pkg::MODE_LIST && count_r > dq_pkg::CNT_W'(1)) begin
          state_nxt = dq_pkg::FE_LIST;
        end
      end
      dq_pkg::FE_LIST: begin
        if (credit_ok && list_last) begin
          state_nxt = dq_pkg::FE_ACCEPT;
        end
      end
      default: state_nxt = dq_pkg::FE_ACCEPT;
    endcase
  end

  always_comb begin
    in_ch.ready   = 1'b0;
    front_nxt     = front_r;
    count_nxt     = count_r;
    lidx_nxt      = lidx_r;
    wr_en         = 1'b0;
    wr_addr       = front_r;
    rd_en         = 1'b0;
    rd_addr       = front_r;
    s1_valid_nxt  = 1'b0;
    s1_ram_nxt    = 1'b0;
    s1_status_nxt = dq_pkg::ST_OK;
    s1_final_nxt  = 1'b1;
    case (state_r)
      dq_pkg::FE_ACCEPT: begin
        in_ch.ready = credit_ok;
        if (accept) begin
          case (in_ch.mode)
            dq_pkg::MODE_PUSH_FRONT, dq_pkg::MODE_PUSH_BACK: begin
              s1_valid_nxt = 1'b1;
              if (count_r == dq_pkg::CNT_W'(dq_pkg::DEPTH)) begin
                s1_status_nxt = dq_pkg::ST_FULL;
              end else begin
                wr_en     = 1'b1;
                count_nxt = count_r + dq_pkg::CNT_W'(1);
                if (in_ch.mode == dq_pkg::MODE_PUSH_FRONT) begin
                  wr_addr   = front_dec;
                  front_nxt = front_dec;
                end else begin
                  wr_addr = dq_pkg::ring_add(front_r, count_r);
                end
              end
            end
            dq_pkg::MODE_POP_FRONT, dq_pkg::MODE_POP_BACK: begin
              s1_valid_nxt = 1'b1;
              if (count_r == '0) begin
                s1_status_nxt = dq_pkg::ST_EMPTY;
              end else begin
                rd_en      = 1'b1;
                s1_ram_nxt = 1'b1;
                count_nxt  = count_r - dq_pkg::CNT_W'(1);
                if (in_ch.mode == dq_pkg::MODE_POP_FRONT) begin
                  front_nxt = dq_pkg::ring_add(front_r, dq_pkg::CNT_W'(1));
                end else begin
                  rd_addr = dq_pkg::ring_add(front_r, count_r - dq_pkg::CNT_W'(1));
                end
              end
            end
            dq_pkg::MODE_LIST: begin
              s1_valid_nxt = 1'b1;
              if (count_r == '0) begin
                s1_status_nxt = dq_pkg::ST_EMPTY;
              end else begin
                rd_en        = 1'b1;
                s1_ram_nxt   = 1'b1;
                s1_final_nxt = (count_r == dq_pkg::CNT_W'(1));
                lidx_nxt     = dq_pkg::CNT_W'(1);
              end
            end
            default: begin
              // unused codes: drop the item
            end
          endcase
        end
      end
      dq_pkg::FE_LIST: begin
        if (credit_ok) begin
          rd_en        = 1'b1;
          rd_addr      = dq_pkg::ring_add(front_r, lidx_r);
          s1_valid_nxt = 1'b1;
          s1_ram_nxt   = 1'b1;
          s1_final_nxt = list_last;
          lidx_nxt     = lidx_r + dq_pkg::CNT_W'(1);
        end
      end
      default: begin
        in_ch.ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= dq_pkg::FE_ACCEPT;
      front_r    <= '0;
      count_r    <= '0;
      lidx_r     <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      front_r    <= front_nxt;
      count_r    <= count_nxt;
      lidx_r     <= lidx_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_ram_r    <= s1_ram_nxt;
    s1_status_r <= s1_status_nxt;
    s1_final_r  <= s1_final_nxt;
  end

  dq_ram #(
    .WIDTH (dq_pkg::DATA_W),
    .DEPTH (dq_pkg::DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_ch.value_in),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    q_wr.valid          = s1_valid_r;
    q_wr.res.value      = s1_ram_r ? $signed(rd_data) : '0;
    q_wr.res.status     = s1_status_r;
    q_wr.res.final_item = s1_final_r;
  end

endmodule

// ----- src/dq_back.sv -----
// ----------------------------------------------------------------------------
// dq_back
// Output register: drain the result queue onto the result channel.
// ----------------------------------------------------------------------------
module dq_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_not_empty,
  input  dq_pkg::res_t  q_data,
  output logic          q_rd_en,
  dq_out_if.source      out_ch
);

  logic         valid_r, valid_nxt;
  dq_pkg::res_t data_r;

  assign q_rd_en = q_not_empty && (!valid_r || out_ch.ready);

  always_comb begin
    valid_nxt = valid_r;
    if (q_rd_en) begin
      valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd_en) begin
      data_r <= q_data;
    end
  end

  assign out_ch.valid      = valid_r;
  assign out_ch.value_out  = data_r.value;
  assign out_ch.status     = data_r.status;
  assign out_ch.final_item = data_r.final_item;

endmodule

// ----- src/double_ended_queue_unit.sv -----
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// Bounded double-ended queue of signed 32-bit values in a ring store.
//
//   channel   direction  handshake          payload
//   in_ch     sink       valid / ready      mode[2:0], value_in[31:0]
//   out_ch    source     valid / ready      value_out[31:0], status[1:0], final_item
//
// Pushes and pops may follow back to back while the result queue has room. A
// listing holds the input while it reads each entry in turn (one store read
// port); an empty listing gives one empty answer. A result passes the read
// stage, result queue and output register before valid rises. Reset clears
// the ring pointers and control state only; the store needs no clearing pass. A
// four-entry result queue lets the output stall while the front end runs until full.
// ----------------------------------------------------------------------------
module double_ended_queue_unit (
  input  logic      clk,
  input  logic      rst_n,
  dq_in_if.sink     in_ch,
  dq_out_if.source  out_ch
);

  dq_pkg::q_wr_t               q_wr;
  dq_pkg::res_t                q_data;
  logic [dq_pkg::QCNT_W-1:0]   q_count;
  logic                        q_rd_en;
  logic                        q_not_empty;

  // Front end: classify each transfer, update ring pointers, access the store.
  dq_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_count (q_count),
    .q_wr    (q_wr)
  );

  // Result queue: decouple the front end from output stalls.
  dq_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (q_wr),
    .rd_en   (q_rd_en),
    .rd_data (q_data),
    .count   (q_count)
  );

  assign q_not_empty = (q_count != '0);

  // Back end: hold each result in the output register until transferred.
  dq_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_data      (q_data),
    .q_rd_en     (q_rd_en),
    .out_ch      (out_ch)
  );

  // The credit check must keep the result queue from overflowing.
  a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (q_count == dq_pkg::QCNT_W'(dq_pkg::QDEPTH)) |-> (!q_wr.valid || q_rd_en))
    else $error("result queue overflow");

  // An empty or full status always ends the run for its item.
  a_error_is_final: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status != dq_pkg::ST_OK) |-> out_ch.final_item)
    else $error("non-ok result not marked final");

  // Empty and full results carry a zero value.
  a_error_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status != dq_pkg::ST_OK) |-> (out_ch.value_out == '0))
    else $error("non-ok result with nonzero value");

  // Never pop from an empty result queue.
  a_queue_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_rd_en |-> (q_count != '0))
    else $error("result queue underflow");

endmodule

// ----- verif/dq_checker.sv -----
// ----------------------------------------------------------------------------
// dq_checker
// Watches both channels of the double-ended queue unit. It mirrors the ring
// store for every operation transfer and checks each result transfer, field by
// field, against the oldest answer still owed.
// ----------------------------------------------------------------------------
module dq_checker
  import dq_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  dq_in_if     in_mon,
  dq_out_if    out_mon,
  output int   fail_count,
  output int   pending,
  output int   ops_seen,
  output int   results_seen,
  output int   full_seen,
  output int   empty_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_LIMIT = 10;

  logic [DATA_W-1:0] mirror_ring [DEPTH];
  int unsigned       mirror_head;
  int unsigned       mirror_fill;
  res_t              owed_answers [$];

  function automatic int unsigned ring_slot(int unsigned off);
    return (mirror_head + off) % DEPTH;
  endfunction

  function automatic res_t make_answer(logic [DATA_W-1:0] v, status_t st, logic fin);
    res_t r;
    r.value      = v;
    r.status     = st;
    r.final_item = fin;
    return r;
  endfunction

  // Apply one operation to the mirror and queue the answers it owes.
  task automatic mirror_deque_op(logic [MODE_W-1:0] op, logic [DATA_W-1:0] val);
    int unsigned p;
    case (op)
      MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
        if (mirror_fill >= DEPTH) begin
          owed_answers.push_back(make_answer('0, ST_FULL, 1'b1));
          full_seen++;
        end else begin
          if (op == MODE_PUSH_FRONT) begin
            mirror_head = ring_slot(DEPTH - 1);
            p = mirror_head;
          end else begin
            p = ring_slot(mirror_fill);
          end
          mirror_ring[p] = val;
          mirror_fill++;
          owed_answers.push_back(make_answer('0, ST_OK, 1'b1));
        end
      end
      MODE_POP_FRONT, MODE_POP_BACK: begin
        if (mirror_fill == 0) begin
          owed_answers.push_back(make_answer('0, ST_EMPTY, 1'b1));
          empty_seen++;
        end else begin
          if (op == MODE_POP_FRONT) begin
            p = mirror_head;
            mirror_head = ring_slot(1);
          end else begin
            p = ring_slot(mirror_fill - 1);
          end
          mirror_fill--;
          owed_answers.push_back(make_answer(mirror_ring[p], ST_OK, 1'b1));
        end
      end
      MODE_LIST: begin
        if (mirror_fill == 0) begin
          owed_answers.push_back(make_answer('0, ST_EMPTY, 1'b1));
          empty_seen++;
        end else begin
          for (int unsigned i = 0; i < mirror_fill; i++) begin
            owed_answers.push_back(make_answer(mirror_ring[ring_slot(i)], ST_OK,
                                               i + 1 == mirror_fill));
          end
        end
      end
      default: ;  // unused codes: no answer, no state change
    endcase
  endtask

  task automatic check_answer();
    res_t want;
    results_seen++;
    if (owed_answers.size() == 0) begin
      fail_count++;
      if (fail_count <= REPORT_LIMIT) begin
        $display("%t: result with nothing owed: value %0d status %0d final %0b", $realtime,
                 out_mon.value_out, out_mon.status, out_mon.final_item);
      end
    end else begin
      want = owed_answers.pop_front();
      if (out_mon.value_out !== want.value || out_mon.status !== want.status ||
          out_mon.final_item !== want.final_item) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT) begin
          $display("%t: mismatch: expected value %0d status %0d final %0b, got value %0d status %0d final %0b",
                   $realtime, want.value, want.status, want.final_item,
                   out_mon.value_out, out_mon.status, out_mon.final_item);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      mirror_head  = 0;
      mirror_fill  = 0;
      owed_answers.delete();
      fail_count   = 0;
      ops_seen     = 0;
      results_seen = 0;
      full_seen    = 0;
      empty_seen   = 0;
      pending     <= 0;
    end else begin
      if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1) begin
        ops_seen++;
        mirror_deque_op(in_mon.mode, in_mon.value_in);
      end
      if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1) begin
        check_answer();
      end
      pending <= owed_answers.size();
    end
  end

endmodule

// ----- verif/tb_double_ended_queue_unit.sv -----
// ----------------------------------------------------------------------------
// tb_double_ended_queue_unit
// Regression for the double-ended queue unit. A short directed sequence hits
// the empty store, the value extremes and the unused operation codes; four
// random phases then vary sender idling and receiver stalls, with one long
// output hold that backs the unit up into its input. dq_checker mirrors the
// store and compares every result.
// ----------------------------------------------------------------------------
module tb_double_ended_queue_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import dq_pkg::*;

  localparam int HALF_PERIOD    = 6;
  localparam int RESET_CYCLES   = 12;
  localparam int PHASE_ITEMS    = 75;
  localparam int SEGMENT_ITEMS  = 24;
  localparam int HOLD_CYCLES    = 90;
  localparam int SETTLE_CYCLES  = 20;
  localparam int WATCHDOG_LIMIT = 3000;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  dq_in_if  in_ch ();
  dq_out_if out_ch ();

  int fail_count, pending, ops_seen, results_seen, full_seen, empty_seen;

  // Handshake pressure knobs. Written only at rising edges, read at falling
  // edges, so the two processes never race on them.
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int hold_token   = 0;
  int idle_cycles  = 0;

  double_ended_queue_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  dq_checker i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .fail_count   (fail_count),
    .pending      (pending),
    .ops_seen     (ops_seen),
    .results_seen (results_seen),
    .full_seen    (full_seen),
    .empty_seen   (empty_seen)
  );

  always begin
    #(HALF_PERIOD) clk = 1'b1;
    #(HALF_PERIOD) clk = 1'b0;
  end

  // Receiver: stall at the phase rate; on a new hold token, hold ready low
  // for a long stretch counted here while the sender keeps offering.
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen    = 0;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // Watchdog: end the run when neither channel moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d results owed",
                 WATCHDOG_LIMIT, pending);
        $display("double_ended_queue_unit regression: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Offer one operation and hold it until the transfer. Entered and left at
  // a falling edge; valid stays high when the next item follows at once.
  task automatic send_op(logic [MODE_W-1:0] op, logic [DATA_W-1:0] val);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.mode     <= op;
    in_ch.value_in <= val;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    @(negedge clk);
  endtask

  // Drop valid and wait at rising edges until every owed result is in.
  task automatic wait_for_drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Pick an operation; push_pct steers the fill level so that the store
  // regularly runs full or empty.
  function automatic logic [MODE_W-1:0] pick_mode(int push_pct);
    int r;
    r = $urandom_range(99);
    if (r < 3) begin
      return MODE_W'($urandom_range(7, 5));
    end else if (r < 12) begin
      return MODE_LIST;
    end else if ($urandom_range(99) < push_pct) begin
      return $urandom_range(1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
    end else begin
      return $urandom_range(1) ? MODE_POP_BACK : MODE_POP_FRONT;
    end
  endfunction

  // One random phase. Called at a rising edge with nothing owed; the knobs
  // change here, before the next falling edge.
  task automatic run_phase(int tx_pct, int rx_pct, bit long_hold);
    int done;
    int push_pct;
    logic [MODE_W-1:0] op;
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    if (long_hold) begin
      hold_token++;
    end
    push_pct = 95;
    done     = 0;
    @(negedge clk);
    while (done < PHASE_ITEMS) begin
      // Switch fill bias every segment: fill up, churn, drain.
      if (done % SEGMENT_ITEMS == SEGMENT_ITEMS - 1) begin
        case ($urandom_range(2))
          0:       push_pct = 95;
          1:       push_pct = 50;
          default: push_pct = 10;
        endcase
      end
      op = pick_mode(push_pct);
      send_op(op, pick_value());
      // Unused codes are ignored by the unit and do not count.
      if (op <= MODE_LIST) begin
        done++;
      end
    end
    wait_for_drain();
  endtask

  initial begin
    in_ch.valid    = 1'b0;
    in_ch.mode     = MODE_PUSH_FRONT;
    in_ch.value_in = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty store answers, unused codes, value extremes, wrap of
    // the front index below zero, list of a mixed queue, pops to empty.
    send_op(MODE_LIST, '0);
    send_op(MODE_POP_FRONT, '0);
    send_op(MODE_POP_BACK, '0);
    send_op(MODE_W'(5), 32'h1234_5678);
    send_op(MODE_W'(6), '0);
    send_op(MODE_W'(7), '1);
    send_op(MODE_PUSH_FRONT, 32'h7fff_ffff);
    send_op(MODE_PUSH_BACK, 32'h8000_0000);
    send_op(MODE_PUSH_FRONT, '1);
    send_op(MODE_PUSH_BACK, '0);
    send_op(MODE_LIST, '0);
    send_op(MODE_POP_BACK, '0);
    send_op(MODE_POP_FRONT, '0);
    send_op(MODE_POP_BACK, '0);
    send_op(MODE_POP_FRONT, '0);
    send_op(MODE_POP_FRONT, '0);
    send_op(MODE_LIST, '0);
    wait_for_drain();

    // Random: back to back with a long output hold, sender idle,
    // receiver stalling, then light idling on both sides.
    run_phase(0, 0, 1'b1);
    run_phase(84, 0, 1'b0);
    run_phase(0, 84, 1'b0);
    run_phase(7, 7, 1'b0);

    // Let any trailing activity through the pipeline before the verdict.
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d operation transfers and %0d checked results in four handshake phases",
             ops_seen, results_seen);
    $display("%0d pushes refused on a full store, %0d empty-store answers, one long output hold",
             full_seen, empty_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("double_ended_queue_unit regression: pass");
    end else begin
      $display("double_ended_queue_unit regression: fail");
    end
    $finish;
  end

endmodule
